FILE: hdl/trff_pkg.sv
// ----------------------------------------------------------------------------
// trff_pkg
// Types and constants shared by the triple 0xff frame receiver modules.
// ----------------------------------------------------------------------------
package trff_pkg;

  localparam logic [7:0] TERM_BYTE = 8'hff;
  localparam logic [7:0] INIT_BYTE = 8'h91;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_INIT_MIN_LEN = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd2;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd300;
  localparam logic [7:0] INIT_MIN_LEN_RST = 8'd8;
  localparam logic [11:0] MAX_FRAME_LEN_RST = 12'd1536;

  localparam int MaxResults = 3;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] count;
  } result_t;

  typedef struct packed {
    logic [1:0]                   num;
    result_t [MaxResults-1:0]     res;
  } bundle_t;

endpackage

FILE: hdl/trff_if.sv
// ----------------------------------------------------------------------------
// trff_in_if / trff_out_if
// Valid/ready channels for received bytes and ticks, and for result words.
// ----------------------------------------------------------------------------
interface trff_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface trff_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] count;
  logic        last;

  modport source (output valid, output kind, output data_byte, output count, output last,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input count, input last,
                output ready);
endinterface

FILE: hdl/triple_ff_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// triple_ff_frame_receiver_core
// Byte-wise receiver for frames ended by three 0xff bytes, with init-run
// counting and an idle timeout driven by millisecond ticks.
//
// in_ch carries one word per received byte (opcode 0) or per millisecond tick
// (opcode 1). out_ch carries result words: data bytes, frame end with payload
// length, frame abort, or init event with its count; last marks the final
// result word of one input word. Held 0xff bytes come out ahead of the byte
// that shows they were payload.
// The results of an input word form one bundle, registered when the word is
// accepted and then written into a two-bundle queue, whose head supplies the
// result words. One result word leaves per cycle while out_ch.ready is high.
// in_ch.ready is low while a bundle is in flight and the queue already holds
// one, or the queue is full: a stalled receiver holds input back without
// losing results. New input words are taken while earlier results still wait
// in the queue, as long as it has room.
// Configuration writes go through cfg_wr_en, cfg_index and cfg_wr_data; the
// user must write only while the block is idle, which it does not enforce.
// Reset clears all control state and loads timeout 300, init length 8, frame
// max 1536.
// ----------------------------------------------------------------------------
module triple_ff_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,
  trff_in_if.sink     in_ch,
  trff_out_if.source  out_ch
);
  import trff_pkg::*;

  logic       accept;
  logic       push;
  bundle_t    bundle;
  logic [1:0] level;
  result_t    out_res;

  // room for the bundle in flight plus the new one
  assign in_ch.ready = (level == 2'd0) || (level == 2'd1 && !push);
  assign accept      = in_ch.valid && in_ch.ready;

  trff_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .opcode      (in_ch.opcode),
    .rx_byte     (in_ch.rx_byte),
    .push        (push),
    .bundle      (bundle)
  );

  trff_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .bundle    (bundle),
    .level     (level),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res),
    .out_last  (out_ch.last)
  );

  assign out_ch.kind      = out_res.kind;
  assign out_ch.data_byte = out_res.data_byte;
  assign out_ch.count     = out_res.count;

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> bundle.num != 2'd0)
    else $error("empty bundle pushed");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    push |-> level != 2'd2)
    else $error("bundle pushed into full queue");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("bundle queue level out of range");

  a_valid_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result offered right after reset");

endmodule

FILE: hdl/trff_engine.sv
// ----------------------------------------------------------------------------
// trff_engine
// Holds the deframer state and configuration registers and turns one accepted
// word into a bundle of up to three results.
// ----------------------------------------------------------------------------
module trff_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wr_data,
  input  logic              accept,
  input  logic              opcode,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output trff_pkg::bundle_t bundle
);
  import trff_pkg::*;

  logic [15:0] idle_timeout_ms;
  logic [7:0]  init_min_len;
  logic [11:0] max_frame_len;

  logic [11:0] frame_count, frame_count_next;
  logic [1:0]  ff_run, ff_run_next;
  logic [15:0] init_run, init_run_next;
  logic [15:0] idle_ms, idle_ms_next;
  logic        timing_active, timing_active_next;
  logic        frame_all_init, frame_all_init_next;

  bundle_t     bundle_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ms <= IDLE_TIMEOUT_RST;
      init_min_len    <= INIT_MIN_LEN_RST;
      max_frame_len   <= MAX_FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT:  idle_timeout_ms <= cfg_wr_data;
        REG_INIT_MIN_LEN:  init_min_len <= cfg_wr_data[7:0];
        REG_MAX_FRAME_LEN: max_frame_len <= cfg_wr_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [11:0] cap;
    logic [15:0] limit;
    logic [7:0]  need;
    logic [15:0] idle_inc;
    logic        ovf;
    logic [11:0] fc_eff;
    logic [11:0] fc_new;
    logic [1:0]  ff_eff;
    logic        all_eff;
    logic [1:0]  idx;

    cap      = (max_frame_len == '0) ? 12'd1 : max_frame_len;
    limit    = (idle_timeout_ms == '0) ? 16'd1 : idle_timeout_ms;
    need     = (init_min_len == '0) ? 8'd1 : init_min_len;
    idle_inc = (idle_ms == 16'hffff) ? idle_ms : idle_ms + 16'd1;
    ovf      = frame_count >= cap;
    fc_eff   = ovf ? 12'd0 : frame_count;
    ff_eff   = ovf ? 2'd0 : ff_run;
    all_eff  = ovf ? 1'b1 : frame_all_init;
    fc_new   = fc_eff + 12'd1;
    idx      = 2'd0;

    frame_count_next    = frame_count;
    ff_run_next         = ff_run;
    init_run_next       = init_run;
    idle_ms_next        = idle_ms;
    timing_active_next  = timing_active;
    frame_all_init_next = frame_all_init;
    bundle_next         = '0;

    if (opcode == OP_BYTE) begin
      idle_ms_next       = '0;
      timing_active_next = 1'b1;
      if (frame_count == '0 && rx_byte == INIT_BYTE) begin
        if (init_run != 16'hffff) init_run_next = init_run + 16'd1;
      end else begin
        if (init_run != '0) begin
          bundle_next.res[idx] = '{kind: KIND_INIT, data_byte: '0, count: init_run};
          idx = idx + 2'd1;
          init_run_next = '0;
        end
        if (ovf) begin
          bundle_next.res[idx] = '{kind: KIND_ABORT, data_byte: '0, count: '0};
          idx = idx + 2'd1;
        end
        if (rx_byte == TERM_BYTE) begin
          if (ff_eff >= 2'd2) begin
            bundle_next.res[idx] = '{kind: KIND_END, data_byte: '0,
                                     count: {4'd0, fc_new - 12'd3}};
            idx = idx + 2'd1;
            frame_count_next    = '0;
            ff_run_next         = '0;
            frame_all_init_next = 1'b1;
          end else begin
            ff_run_next         = ff_eff + 2'd1;
            frame_count_next    = fc_new;
            frame_all_init_next = 1'b0;
          end
        end else begin
          for (int i = 0; i < 2; i++) begin
            if (ff_eff > i[1:0] && idx != 2'd3) begin
              bundle_next.res[idx] = '{kind: KIND_DATA, data_byte: TERM_BYTE, count: '0};
              idx = idx + 2'd1;
            end
          end
          if (idx != 2'd3) begin
            bundle_next.res[idx] = '{kind: KIND_DATA, data_byte: rx_byte, count: '0};
            idx = idx + 2'd1;
          end
          ff_run_next         = '0;
          frame_count_next    = fc_new;
          frame_all_init_next = all_eff & (rx_byte == INIT_BYTE);
        end
      end
    end else if (timing_active) begin
      if (idle_inc < limit) begin
        idle_ms_next = idle_inc;
      end else begin
        if (init_run != '0) begin
          bundle_next.res[idx] = '{kind: KIND_INIT, data_byte: '0, count: init_run};
          idx = idx + 2'd1;
          init_run_next = '0;
        end else if (frame_count != '0) begin
          if (frame_all_init && frame_count >= {4'd0, need}) begin
            bundle_next.res[idx] = '{kind: KIND_INIT, data_byte: '0,
                                     count: {4'd0, frame_count}};
          end else begin
            bundle_next.res[idx] = '{kind: KIND_ABORT, data_byte: '0, count: '0};
          end
          idx = idx + 2'd1;
          frame_count_next    = '0;
          ff_run_next         = '0;
          frame_all_init_next = 1'b1;
        end
        timing_active_next = 1'b0;
        idle_ms_next       = '0;
      end
    end
    bundle_next.num = idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= '0;
      ff_run         <= '0;
      init_run       <= '0;
      idle_ms        <= '0;
      timing_active  <= 1'b0;
      frame_all_init <= 1'b1;
      push           <= 1'b0;
    end else begin
      push <= accept && (bundle_next.num != '0);
      if (accept) begin
        frame_count    <= frame_count_next;
        ff_run         <= ff_run_next;
        init_run       <= init_run_next;
        idle_ms        <= idle_ms_next;
        timing_active  <= timing_active_next;
        frame_all_init <= frame_all_init_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) bundle <= bundle_next;
  end

endmodule

FILE: hdl/trff_drain.sv
// ----------------------------------------------------------------------------
// trff_drain
// Two-entry queue of result bundles, emptied one result word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module trff_drain (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  trff_pkg::bundle_t bundle,
  output logic [1:0]        level,
  output logic              out_valid,
  input  logic              out_ready,
  output trff_pkg::result_t out_res,
  output logic              out_last
);
  import trff_pkg::*;

  bundle_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] sub;
  logic       pop;
  bundle_t    head;

  assign head      = mem[rd_ptr];
  assign out_valid = level != '0;
  assign out_res   = head.res[sub];
  assign out_last  = sub == (head.num - 2'd1);
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= bundle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      sub    <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) begin
        if (out_last) begin
          rd_ptr <= ~rd_ptr;
          sub    <= '0;
        end else begin
          sub <= sub + 2'd1;
        end
      end
      level <= level + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: bench/trff_frame_checker.sv
// ----------------------------------------------------------------------------
// trff_frame_checker
// Watches the byte/tick channel and the result channel of the triple 0xff
// frame receiver. It keeps its own copy of the receiver state and registers,
// works out the result words for every accepted input word, and compares each
// accepted result word in order against them, counting failures.
// ----------------------------------------------------------------------------
module trff_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data,
  trff_in_if          in_ch,
  trff_out_if         out_ch,
  output int          fail_count,
  output int          queued,
  output int          words_in,
  output int          words_out
);

  timeunit 1ns;
  timeprecision 1ps;

  import trff_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] count;
    logic        last;
  } rx_event_t;

  rx_event_t pending_events[$];

  logic [15:0] timeout_ms;
  logic [7:0]  min_init_len;
  logic [11:0] max_len;

  logic [11:0] frame_len;
  logic [1:0]  ff_held;
  logic [15:0] init_len;
  logic [15:0] idle_cnt;
  logic        timing_on;
  logic        all_init;

  function automatic void push_event(kind_t k, logic [7:0] b, logic [15:0] c);
    rx_event_t ev;
    ev.kind = k;
    ev.data_byte = b;
    ev.count = c;
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  function automatic void drop_frame();
    frame_len = '0;
    ff_held = '0;
    all_init = 1'b1;
  endfunction

  task automatic predict_word(input logic op, input logic [7:0] b);
    logic [11:0] cap;
    logic [15:0] limit;
    logic [7:0]  need;
    int          n0;
    rx_event_t   tail;
    n0 = pending_events.size();
    cap = (max_len == 0) ? 12'd1 : max_len;
    limit = (timeout_ms == 0) ? 16'd1 : timeout_ms;
    need = (min_init_len == 0) ? 8'd1 : min_init_len;
    if (op == OP_BYTE) begin
      idle_cnt = '0;
      timing_on = 1'b1;
      if (frame_len == 0 && b == INIT_BYTE) begin
        if (init_len != 16'hffff) init_len++;
      end else begin
        if (init_len != 0) begin
          push_event(KIND_INIT, 8'd0, init_len);
          init_len = '0;
        end
        if (frame_len >= cap) begin
          push_event(KIND_ABORT, 8'd0, 16'd0);
          drop_frame();
        end
        frame_len++;
        if (b != INIT_BYTE) all_init = 1'b0;
        if (b == TERM_BYTE) begin
          if (ff_held >= 2) begin
            push_event(KIND_END, 8'd0, {4'd0, frame_len} - 16'd3);
            drop_frame();
          end else begin
            ff_held++;
          end
        end else begin
          while (ff_held > 0) begin
            push_event(KIND_DATA, TERM_BYTE, 16'd0);
            ff_held--;
          end
          push_event(KIND_DATA, b, 16'd0);
        end
      end
    end else if (timing_on) begin
      if (idle_cnt != 16'hffff) idle_cnt++;
      if (idle_cnt >= limit) begin
        if (init_len != 0) begin
          push_event(KIND_INIT, 8'd0, init_len);
          init_len = '0;
        end else if (frame_len != 0) begin
          if (all_init && frame_len >= {4'd0, need}) begin
            push_event(KIND_INIT, 8'd0, {4'd0, frame_len});
          end else begin
            push_event(KIND_ABORT, 8'd0, 16'd0);
          end
          drop_frame();
        end
        timing_on = 1'b0;
        idle_cnt = '0;
      end
    end
    if (pending_events.size() > n0) begin
      tail = pending_events.pop_back();
      tail.last = 1'b1;
      pending_events.push_back(tail);
    end
  endtask

  task automatic check_result();
    rx_event_t exp_ev;
    if (pending_events.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected result word: kind %0d byte %02h count %0d last %0b",
                 $realtime, out_ch.kind, out_ch.data_byte, out_ch.count, out_ch.last);
    end else begin
      exp_ev = pending_events.pop_front();
      if (exp_ev.kind != out_ch.kind || exp_ev.data_byte != out_ch.data_byte ||
          exp_ev.count != out_ch.count || exp_ev.last != out_ch.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] result %0d: expected kind %0d byte %02h count %0d last %0b,",
                   $realtime, words_out, exp_ev.kind, exp_ev.data_byte, exp_ev.count,
                   exp_ev.last,
                   " got kind %0d byte %02h count %0d last %0b",
                   out_ch.kind, out_ch.data_byte, out_ch.count, out_ch.last);
      end
    end
    words_out++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_ms = IDLE_TIMEOUT_RST;
      min_init_len = INIT_MIN_LEN_RST;
      max_len = MAX_FRAME_LEN_RST;
      init_len = '0;
      idle_cnt = '0;
      timing_on = 1'b0;
      drop_frame();
      pending_events.delete();
      fail_count = 0;
      words_in = 0;
      words_out = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IDLE_TIMEOUT:  timeout_ms = cfg_wr_data;
          REG_INIT_MIN_LEN:  min_init_len = cfg_wr_data[7:0];
          REG_MAX_FRAME_LEN: max_len = cfg_wr_data[11:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.opcode, in_ch.rx_byte);
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
    queued = pending_events.size();
  end

endmodule

FILE: bench/triple_ff_frame_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// triple_ff_frame_receiver_core_tb
// Drives received bytes and millisecond ticks into the frame receiver under
// several register settings and handshake pacing modes: reset defaults, a
// directed pass over terminators, held 0xff bytes, init runs, overflow and
// timeouts, then random frames, init runs, tick bursts and noise, and a short
// closing init run. A checker beside the block scores every result.
// ----------------------------------------------------------------------------
module triple_ff_frame_receiver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trff_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wr_data;

  trff_in_if  in_ch();
  trff_out_if out_ch();

  int fail_count;
  int queued;
  int words_in;
  int words_out;

  int words_sent = 0;
  int settings_used = 0;
  int send_idle = 0;
  int recv_idle = 0;

  logic [15:0] cur_timeout;
  logic [11:0] cur_max;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  triple_ff_frame_receiver_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  trff_frame_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .queued      (queued),
    .words_in    (words_in),
    .words_out   (words_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    out_fire <= out_ch.valid && out_ch.ready;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || in_fire || out_fire) stall = 0;
      else stall++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.rx_byte <= b;
    do @(negedge clk); while (!in_fire);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic int tick_hint();
    if (cur_timeout == 0) return 2;
    if (cur_timeout > 11) return 12;
    return int'(cur_timeout) + 1;
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (queued != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [15:0] t, input logic [7:0] m, input logic [11:0] f);
    wait_idle();
    write_reg(REG_IDLE_TIMEOUT, t);
    write_reg(REG_INIT_MIN_LEN, {8'd0, m});
    write_reg(REG_MAX_FRAME_LEN, {4'd0, f});
    cur_timeout = t;
    cur_max = f;
    settings_used++;
  endtask

  task automatic random_traffic(input int n);
    int          stop;
    int          pick;
    int          hint;
    int          fill;
    logic [7:0]  b;
    stop = words_sent + n;
    while (words_sent < stop) begin
      pick = $urandom_range(0, 99);
      hint = (cur_max == 0) ? 2 : ((cur_max > 22) ? 24 : int'(cur_max) + 2);
      if (pick < 45) begin
        repeat ($urandom_range(0, hint)) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) b = TERM_BYTE;
          else if (pick < 30) b = INIT_BYTE;
          else b = 8'($urandom_range(0, 255));
          send_word(OP_BYTE, b);
        end
        repeat (3) send_word(OP_BYTE, TERM_BYTE);
      end else if (pick < 58) begin
        repeat ($urandom_range(1, 6)) send_word(OP_BYTE, INIT_BYTE);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, tick_hint())) send_tick();
      end else if (pick < 88) begin
        fill = (cur_max == 0) ? 1 : int'(cur_max);
        if (fill <= 40) begin
          repeat (fill) begin
            do b = 8'($urandom_range(0, 255)); while (b == INIT_BYTE || b == TERM_BYTE);
            send_word(OP_BYTE, b);
          end
        end
        repeat ($urandom_range(1, 6)) send_word(OP_BYTE, INIT_BYTE);
        repeat (tick_hint()) send_tick();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) send_tick();
          else send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = REG_IDLE_TIMEOUT;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_BYTE;
    in_ch.rx_byte = '0;
    cur_timeout = IDLE_TIMEOUT_RST;
    cur_max = MAX_FRAME_LEN_RST;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 32;
    recv_idle = 87;

    // reset defaults: short frame, then a partial frame closed by the 300 ms timeout
    send_word(OP_BYTE, 8'h12);
    repeat (3) send_word(OP_BYTE, TERM_BYTE);
    send_word(OP_BYTE, 8'h34);
    repeat (300) send_tick();

    apply_config(16'd2, 8'd3, 12'd4);
    // init run flushed by a data byte, overflow by 0x91, all-init partial frame timeout
    send_word(OP_BYTE, INIT_BYTE);
    send_word(OP_BYTE, INIT_BYTE);
    send_word(OP_BYTE, 8'h22);
    repeat (3) send_word(OP_BYTE, 8'h01);
    repeat (3) send_word(OP_BYTE, INIT_BYTE);
    send_tick();
    send_tick();
    // empty frame, held 0xff released, mixed partial frame aborted, tick while idle
    repeat (3) send_word(OP_BYTE, TERM_BYTE);
    send_word(OP_BYTE, TERM_BYTE);
    send_word(OP_BYTE, TERM_BYTE);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_BYTE, 8'h00);
    send_tick();
    send_tick();
    send_tick();

    for (int mode = 0; mode < 3; mode++) begin
      wait_idle();
      case (mode)
        0: begin send_idle = 32; recv_idle = 87; end
        1: begin send_idle = 87; recv_idle = 32; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int k = 0; k < 2; k++) begin
        case (mode * 2 + k)
          0: apply_config(16'd5, 8'd4, 12'd16);
          1: apply_config(16'd0, 8'd0, 12'd0);
          2: apply_config(16'd65535, 8'd255, 12'd4095);
          3: apply_config(16'd3, 8'd2, 12'd40);
          4: apply_config(16'd1, 8'd1, 12'd1);
          default: apply_config(16'd2, 8'd3, 12'd6);
        endcase
        random_traffic(15);
      end
    end

    // close anything open, then a short init run flushed by a data byte
    send_tick();
    send_tick();
    repeat (6) send_word(OP_BYTE, INIT_BYTE);
    send_word(OP_BYTE, 8'h00);

    wait_idle();
    repeat (12) @(negedge clk);

    $display("run covered %0d input words and %0d result words", words_in, words_out);
    $display("over reset defaults plus %0d register settings, three pacing modes",
             settings_used);
    if (fail_count == 0 && queued == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
